// ===== src/frame_ring_with_loop_replay_defines.svh =====
// Assertion macros for the frame ring with loop replay.
// Included by the top level only; depends on nothing else.
`ifndef FRAME_RING_WITH_LOOP_REPLAY_DEFINES_SVH
`define FRAME_RING_WITH_LOOP_REPLAY_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FRL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that forces a consequence in the same cycle.
`define FRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An antecedent that forces a consequence in the next cycle.
`define FRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/frl_pkg.sv =====
// Shared types and constants for the frame ring with loop replay.
// Used by the top level; has no dependencies.
package frl_pkg;

  // Default number of frame slots in the ring.
  localparam int SLOTS_DEFAULT = 16;

  // Operation codes carried in the command beat.
  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_PEEK     = 3'd1;
  localparam logic [2:0] OP_POP      = 3'd2;
  localparam logic [2:0] OP_SNAPSHOT = 3'd3;
  localparam logic [2:0] OP_RESTORE  = 3'd4;

  // Status codes returned in the response beat.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FAIL         = 3'd1;
  localparam logic [2:0] ST_STALE        = 3'd2;
  localparam logic [2:0] ST_SHIFT_OVF    = 3'd3;
  localparam logic [2:0] ST_DEADLINE_OVF = 3'd4;

  // One stored frame, as held in the slot memory.
  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] seq_no;
    logic [31:0] payload;
  } frame_t;

  // Command beat.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] in_deadline;
    logic [31:0] in_sequence;
    logic [31:0] in_payload;
    logic [63:0] loop_length;
    logic [31:0] iteration;
  } cmd_t;

  // Response beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_deadline;
    logic [31:0] out_sequence;
    logic [31:0] out_payload;
    logic [4:0]  occupancy;
    logic [31:0] drop_total;
    logic        loop_ready;
    logic [63:0] loop_period;
  } rsp_t;

endpackage

// ===== src/frl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds no reset and depends on no package.
module frl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/frame_ring_with_loop_replay.sv =====
// Channel  Direction  Beat    Handshake
// cmd      in         cmd_t   cmd_valid / cmd_stall
// rsp      out        rsp_t   rsp_valid / rsp_stall
//
// Push, unused codes and the empty, no-loop and stale failures answer from idle; peek and
// pop read the head first; snapshot answers at once or reads two deadlines (derived duration);
// restore multiplies and walks the loop frames, ending early on a shift or deadline overflow.
// The walk moves one frame per cycle through the single read port of the slot memory,
// and one 32 x 32 multiplier, used twice, forms the shift.
// Reset is synchronous and clears control state only; a stalled response lets one more in.
//
// Top level of the frame ring with loop replay.
// Depends on frl_pkg, frl_ram and frame_ring_with_loop_replay_defines.svh.
`include "frame_ring_with_loop_replay_defines.svh"

module frame_ring_with_loop_replay #(
  parameter int SLOTS = frl_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  frl_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output frl_pkg::rsp_t rsp
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int IDX_W1 = IDX_W + 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FRAME_W = $bits(frl_pkg::frame_t);
  localparam logic [IDX_W1-1:0] SLOTS_IDX = IDX_W1'(SLOTS);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_READ       = 8'b0000_0010,
    S_SNAP_FIRST = 8'b0000_0100,
    S_SNAP_LAST  = 8'b0000_1000,
    S_MUL_LO     = 8'b0001_0000,
    S_MUL_HI     = 8'b0010_0000,
    S_CHECK      = 8'b0100_0000,
    S_WALK       = 8'b1000_0000
  } state_t;

  // Reduce a sum below twice the slot count to a slot index.
  function automatic logic [IDX_W-1:0] wrap_sum(input logic [IDX_W1-1:0] s);
    logic [IDX_W1-1:0] r;
    r = (s >= SLOTS_IDX) ? (s - SLOTS_IDX) : s;
    return r[IDX_W-1:0];
  endfunction

  // Control registers.
  state_t            state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [31:0]       drop_count, drop_next;
  logic              loop_armed, loop_armed_next;
  logic [IDX_W-1:0]  loop_start, loop_start_next;
  logic [CNT_W-1:0]  loop_frames, loop_frames_next;
  logic [63:0]       loop_span, loop_span_next;
  logic [31:0]       last_iter, last_iter_next;
  logic [IDX_W-1:0]  walk_cur, walk_cur_next;
  logic [CNT_W-1:0]  walk_left, walk_left_next;

  // Working registers of the item in progress.
  logic [2:0]        op_q, op_next;
  logic [31:0]       iter_q, iter_next;
  logic [31:0]       step_q, step_next;
  logic [63:0]       first_dl, first_dl_next;
  logic [63:0]       prod_lo, prod_lo_next;
  logic [63:0]       prod_hi, prod_hi_next;
  logic [63:0]       shift, shift_next;
  logic [31:0]       seq_add, seq_add_next;

  // Slot memory ports.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  frl_pkg::frame_t   wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  frl_pkg::frame_t   rd_data;

  // Response produced this cycle, and the two-entry response buffer.
  logic              res_valid;
  logic [2:0]        res_status;
  frl_pkg::frame_t   res_frame;
  frl_pkg::rsp_t     res;
  frl_pkg::rsp_t     skid;
  logic              skid_valid;
  logic              rsp_take;
  logic              cmd_acc;

  // Snapshot commit, shared by the immediate and the derived-duration paths.
  logic              snap_commit;
  logic [63:0]       snap_len;

  // Arithmetic helpers.
  logic [31:0]       mul_b;
  logic [63:0]       mul_out;
  logic [32:0]       mid_sum;
  logic [64:0]       dl_sum;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  walk_nxt;

  // Terms used by the checks.
  logic              pop_read;
  logic              walk_ok;
  logic [CNT_W-1:0]  fill_dec;

  assign cmd_stall = (state != S_IDLE) || skid_valid;
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;

  // Shared multiplier: low half of the duration first, then the high half.
  assign mul_b   = (state == S_MUL_HI) ? loop_span[63:32] : loop_span[31:0];
  assign mul_out = 64'(step_q) * 64'(mul_b);

  assign mid_sum  = {1'b0, prod_hi[31:0]} + {1'b0, prod_lo[63:32]};
  assign dl_sum   = {1'b0, rd_data.deadline} + {1'b0, shift};
  assign last_idx = wrap_sum(IDX_W1'(head) + IDX_W1'(fill) - IDX_W1'(1));
  assign walk_nxt = wrap_sum(IDX_W1'(walk_cur) + IDX_W1'(1));

  frl_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: decodes the command, drives the memory and forms the response.
  always_comb begin
    state_next         = state;
    head_next          = head;
    tail_next          = tail;
    fill_next          = fill;
    drop_next          = drop_count;
    loop_armed_next    = loop_armed;
    loop_start_next    = loop_start;
    loop_frames_next   = loop_frames;
    loop_span_next     = loop_span;
    last_iter_next     = last_iter;
    walk_cur_next      = walk_cur;
    walk_left_next     = walk_left;
    op_next            = op_q;
    iter_next          = iter_q;
    step_next          = step_q;
    first_dl_next      = first_dl;
    prod_lo_next       = prod_lo;
    prod_hi_next       = prod_hi;
    shift_next         = shift;
    seq_add_next       = seq_add;
    wr_en              = 1'b0;
    wr_addr            = tail;
    wr_data            = '{deadline: cmd.in_deadline, seq_no: cmd.in_sequence,
                           payload: cmd.in_payload};
    rd_en              = 1'b0;
    rd_addr            = head;
    res_valid          = 1'b0;
    res_status         = frl_pkg::ST_OK;
    res_frame          = '0;
    snap_commit        = 1'b0;
    snap_len           = cmd.loop_length;

    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          op_next   = cmd.opcode;
          iter_next = cmd.iteration;
          case (cmd.opcode)
            frl_pkg::OP_PUSH: begin
              res_valid = 1'b1;
              if (fill == FULL_CNT) begin
                drop_next  = drop_count + 32'd1;
                res_status = frl_pkg::ST_FAIL;
              end else begin
                wr_en     = 1'b1;
                tail_next = wrap_sum(IDX_W1'(tail) + IDX_W1'(1));
                fill_next = fill + CNT_W'(1);
              end
            end
            frl_pkg::OP_PEEK, frl_pkg::OP_POP: begin
              if (fill == '0) begin
                res_valid  = 1'b1;
                res_status = frl_pkg::ST_FAIL;
              end else begin
                rd_en      = 1'b1;
                state_next = S_READ;
              end
            end
            frl_pkg::OP_SNAPSHOT: begin
              if (fill == '0) begin
                res_valid  = 1'b1;
                res_status = frl_pkg::ST_FAIL;
              end else if (cmd.loop_length != 64'd0) begin
                res_valid   = 1'b1;
                snap_commit = 1'b1;
              end else begin
                rd_en      = 1'b1;
                state_next = S_SNAP_FIRST;
              end
            end
            frl_pkg::OP_RESTORE: begin
              if (!loop_armed || loop_frames == '0) begin
                res_valid  = 1'b1;
                res_status = frl_pkg::ST_FAIL;
              end else if (cmd.iteration <= last_iter) begin
                res_valid  = 1'b1;
                res_status = frl_pkg::ST_STALE;
              end else begin
                step_next  = cmd.iteration - last_iter;
                state_next = S_MUL_LO;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      // Head frame is on the read port.
      S_READ: begin
        res_valid  = 1'b1;
        res_frame  = rd_data;
        state_next = S_IDLE;
        if (op_q == frl_pkg::OP_POP) begin
          head_next = wrap_sum(IDX_W1'(head) + IDX_W1'(1));
          fill_next = fill - CNT_W'(1);
        end
      end

      // First deadline arrives; fetch the last one.
      S_SNAP_FIRST: begin
        first_dl_next = rd_data.deadline;
        rd_en         = 1'b1;
        rd_addr       = last_idx;
        state_next    = S_SNAP_LAST;
      end

      S_SNAP_LAST: begin
        res_valid   = 1'b1;
        snap_commit = 1'b1;
        snap_len    = (rd_data.deadline > first_dl) ? (rd_data.deadline - first_dl) : 64'd1;
        state_next  = S_IDLE;
      end

      S_MUL_LO: begin
        prod_lo_next = mul_out;
        state_next   = S_MUL_HI;
      end

      S_MUL_HI: begin
        prod_hi_next = mul_out;
        state_next   = S_CHECK;
      end

      // Assemble the 96-bit product; anything above 64 bits is an overflow.
      S_CHECK: begin
        if ((prod_hi[63:32] != 32'd0) || mid_sum[32]) begin
          res_valid  = 1'b1;
          res_status = frl_pkg::ST_SHIFT_OVF;
          state_next = S_IDLE;
        end else begin
          shift_next     = {mid_sum[31:0], prod_lo[31:0]};
          seq_add_next   = step_q * 32'(loop_frames);
          rd_en          = 1'b1;
          rd_addr        = loop_start;
          walk_cur_next  = loop_start;
          walk_left_next = loop_frames;
          state_next     = S_WALK;
        end
      end

      // One loop frame per cycle: shift the frame just read, fetch the next.
      S_WALK: begin
        if (dl_sum[64]) begin
          res_valid  = 1'b1;
          res_status = frl_pkg::ST_DEADLINE_OVF;
          state_next = S_IDLE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = walk_cur;
          wr_data = '{deadline: dl_sum[63:0],
                      seq_no:   rd_data.seq_no + seq_add,
                      payload:  rd_data.payload};
          if (walk_left == CNT_W'(1)) begin
            head_next      = loop_start;
            tail_next      = wrap_sum(IDX_W1'(loop_start) + IDX_W1'(loop_frames));
            fill_next      = loop_frames;
            last_iter_next = iter_q;
            res_valid      = 1'b1;
            state_next     = S_IDLE;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = walk_nxt;
            walk_cur_next  = walk_nxt;
            walk_left_next = walk_left - CNT_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Freeze the current contents as the loop.
    if (snap_commit) begin
      loop_frames_next = fill;
      loop_start_next  = head;
      loop_span_next   = snap_len;
      last_iter_next   = 32'd0;
      loop_armed_next  = 1'b1;
    end
  end

  // Response beat reflects the state after this operation.
  always_comb begin
    res.status       = res_status;
    res.out_deadline = res_frame.deadline;
    res.out_sequence = res_frame.seq_no;
    res.out_payload  = res_frame.payload;
    res.occupancy    = 5'(fill_next);
    res.drop_total   = drop_next;
    res.loop_ready   = loop_armed_next;
    res.loop_period  = loop_span_next;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      drop_count  <= '0;
      loop_armed  <= 1'b0;
      loop_start  <= '0;
      loop_frames <= '0;
      loop_span   <= '0;
      last_iter   <= '0;
      walk_cur    <= '0;
      walk_left   <= '0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      tail        <= tail_next;
      fill        <= fill_next;
      drop_count  <= drop_next;
      loop_armed  <= loop_armed_next;
      loop_start  <= loop_start_next;
      loop_frames <= loop_frames_next;
      loop_span   <= loop_span_next;
      last_iter   <= last_iter_next;
      walk_cur    <= walk_cur_next;
      walk_left   <= walk_left_next;
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk) begin
    op_q     <= op_next;
    iter_q   <= iter_next;
    step_q   <= step_next;
    first_dl <= first_dl_next;
    prod_lo  <= prod_lo_next;
    prod_hi  <= prod_hi_next;
    shift    <= shift_next;
    seq_add  <= seq_add_next;
  end

  // Response buffer: output register plus one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_take) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        rsp_valid  <= res_valid;
      end
    end else if (res_valid) begin
      if (!rsp_valid) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      if (skid_valid) begin
        rsp  <= skid;
        skid <= res;
      end else begin
        rsp <= res;
      end
    end else if (res_valid) begin
      if (!rsp_valid) begin
        rsp <= res;
      end else begin
        skid <= res;
      end
    end
  end

  // Checks on the ring and the sequencer.
  assign pop_read = (state == S_READ) && (op_q == frl_pkg::OP_POP);
  assign walk_ok  = loop_armed && (walk_left != '0);
  assign fill_dec = fill - CNT_W'(1);

  `FRL_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= FULL_CNT, "fill count above slot count")
  `FRL_ASSERT_SAME(a_res_room, clk, rst, res_valid, !skid_valid, "response with no buffer room")
  `FRL_ASSERT_SAME(a_walk_loop, clk, rst, state == S_WALK, walk_ok, "walk without a loop")
  `FRL_ASSERT_NEXT(a_pop_count, clk, rst, pop_read, fill == $past(fill_dec), "pop kept its frame")

endmodule

// ===== verif/frame_ring_with_loop_replay_tb.sv =====
// Self-checking testbench for the frame ring with loop replay: a table of directed
// command beats, then random scenarios, each response checked against a local predictor or a typed row's beat.
// Depends on frl_pkg and the frame_ring_with_loop_replay top level only.
module frame_ring_with_loop_replay_tb;

  localparam int RING_SLOTS = frl_pkg::SLOTS_DEFAULT;
  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam int N_ITEMS = 450;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [63:0] DL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    frl_pkg::cmd_t c;
    logic typed;
    frl_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  frl_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  frl_pkg::rsp_t rsp;

  // Predictor state: the ring, its pointers and the frozen loop.
  logic [63:0] slot_dl [RING_SLOTS];
  logic [31:0] slot_seq [RING_SLOTS];
  logic [31:0] slot_pay [RING_SLOTS];
  logic [IDX_W-1:0] head_ptr = '0;
  logic [IDX_W-1:0] tail_ptr = '0;
  logic [IDX_W:0] fill = '0;
  logic [31:0] drops = '0;
  logic loop_ok = 1'b0;
  logic [IDX_W-1:0] loop_base = '0;
  logic [IDX_W:0] loop_nframes = '0;
  logic [63:0] loop_dur = '0;
  logic [31:0] last_iter = '0;

  frl_pkg::rsp_t pending_rsp [$];
  dir_row_t dir_tab [$];
  int fail_count = 0;
  int sent = 0;
  int send_gap_pct = 26;
  int rsp_stall_pct = 74;

  frame_ring_with_loop_replay #(.SLOTS(RING_SLOTS)) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Applies one command to the predicted ring and returns the response it should give.
  function automatic frl_pkg::rsp_t ring_apply(input frl_pkg::cmd_t c);
    frl_pkg::rsp_t r;
    logic [63:0] first_dl;
    logic [63:0] last_dl;
    logic [63:0] len;
    logic [63:0] shift;
    logic [95:0] prod;
    logic [31:0] step;
    logic [31:0] seq_add;
    logic [IDX_W-1:0] k;
    logic ovf;
    r = '0;
    case (c.opcode)
      frl_pkg::OP_PUSH: begin
        if (fill == RING_SLOTS) begin
          drops = drops + 32'd1;
          r.status = frl_pkg::ST_FAIL;
        end else begin
          slot_dl[tail_ptr] = c.in_deadline;
          slot_seq[tail_ptr] = c.in_sequence;
          slot_pay[tail_ptr] = c.in_payload;
          tail_ptr = tail_ptr + 1'b1;
          fill = fill + 1'b1;
        end
      end
      frl_pkg::OP_PEEK, frl_pkg::OP_POP: begin
        if (fill == 0) begin
          r.status = frl_pkg::ST_FAIL;
        end else begin
          r.out_deadline = slot_dl[head_ptr];
          r.out_sequence = slot_seq[head_ptr];
          r.out_payload = slot_pay[head_ptr];
          if (c.opcode == frl_pkg::OP_POP) begin
            head_ptr = head_ptr + 1'b1;
            fill = fill - 1'b1;
          end
        end
      end
      frl_pkg::OP_SNAPSHOT: begin
        if (fill == 0) begin
          r.status = frl_pkg::ST_FAIL;
        end else begin
          loop_nframes = fill;
          loop_base = head_ptr;
          first_dl = slot_dl[head_ptr];
          last_dl = slot_dl[head_ptr + IDX_W'(fill - 1'b1)];
          len = c.loop_length;
          // A zero length takes the span of the deadlines, at least one.
          if (len == 0) len = (last_dl > first_dl) ? last_dl - first_dl : 64'd1;
          loop_dur = len;
          last_iter = '0;
          loop_ok = 1'b1;
        end
      end
      frl_pkg::OP_RESTORE: begin
        if (!loop_ok || loop_nframes == 0) begin
          r.status = frl_pkg::ST_FAIL;
        end else if (c.iteration <= last_iter) begin
          r.status = frl_pkg::ST_STALE;
        end else begin
          step = c.iteration - last_iter;
          prod = 96'(step) * 96'(loop_dur);
          if (prod[95:64] != 0) begin
            r.status = frl_pkg::ST_SHIFT_OVF;
          end else begin
            shift = prod[63:0];
            seq_add = step * 32'(loop_nframes);
            ovf = 1'b0;
            // Frames shifted before an overflowing one keep their new values.
            for (int i = 0; i < loop_nframes; i++) begin
              if (!ovf) begin
                k = loop_base + IDX_W'(i);
                if (slot_dl[k] > DL_MAX - shift) begin
                  ovf = 1'b1;
                end else begin
                  slot_dl[k] = slot_dl[k] + shift;
                  slot_seq[k] = slot_seq[k] + seq_add;
                end
              end
            end
            if (ovf) begin
              r.status = frl_pkg::ST_DEADLINE_OVF;
            end else begin
              head_ptr = loop_base;
              tail_ptr = loop_base + IDX_W'(loop_nframes);
              fill = loop_nframes;
              last_iter = c.iteration;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = fill;
    r.drop_total = drops;
    r.loop_ready = loop_ok;
    r.loop_period = loop_dur;
    return r;
  endfunction

  function automatic frl_pkg::cmd_t mk_cmd(input logic [2:0] op, input logic [63:0] dl,
                                           input logic [31:0] sq, input logic [31:0] pay,
                                           input logic [63:0] len, input logic [31:0] it);
    frl_pkg::cmd_t c;
    c.opcode = op;
    c.in_deadline = dl;
    c.in_sequence = sq;
    c.in_payload = pay;
    c.loop_length = len;
    c.iteration = it;
    return c;
  endfunction

  function automatic frl_pkg::rsp_t mk_rsp(input logic [2:0] st, input logic [63:0] dl,
                                           input logic [31:0] sq, input logic [31:0] pay,
                                           input logic [4:0] occ, input logic [31:0] dr,
                                           input logic rdy, input logic [63:0] per);
    frl_pkg::rsp_t r;
    r.status = st;
    r.out_deadline = dl;
    r.out_sequence = sq;
    r.out_payload = pay;
    r.occupancy = occ;
    r.drop_total = dr;
    r.loop_ready = rdy;
    r.loop_period = per;
    return r;
  endfunction

  // Every field random; scenarios then override the fields that matter.
  function automatic frl_pkg::cmd_t rand_cmd(input logic [2:0] op);
    return mk_cmd(op, {$urandom, $urandom}, $urandom, $urandom, {$urandom, $urandom},
                  $urandom);
  endfunction

  // Small, full-range and near-maximum deadlines, so that overflows happen.
  function automatic logic [63:0] rand_deadline();
    logic [63:0] d;
    case ($urandom_range(3))
      0: d = 64'($urandom_range(1000));
      1: d = {$urandom, $urandom};
      2: d = DL_MAX - 64'($urandom_range(5000));
      default: d = 64'($urandom);
    endcase
    return d;
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Drives one command beat after a random gap, then records what it should return.
  task automatic issue(input frl_pkg::cmd_t c, input bit typed = 1'b0,
                       input frl_pkg::rsp_t want = '0);
    frl_pkg::rsp_t pred;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    pred = ring_apply(c);
    pending_rsp.push_back(typed ? want : pred);
    sent++;
    // Receiver stall-heavy first, then sender idle-heavy and receiver stall-light, then back to back.
    if (sent == N_ITEMS / 3) begin
      send_gap_pct = 74;
      rsp_stall_pct = 26;
    end else if (sent == 2 * N_ITEMS / 3) begin
      send_gap_pct = 0;
      rsp_stall_pct = 0;
    end
  endtask

  // Receiver: random stall on each cycle as the current phase asks.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Response checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    frl_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("status", 64'(want.status), 64'(rsp.status));
        cmp_field("out_deadline", want.out_deadline, rsp.out_deadline);
        cmp_field("out_sequence", 64'(want.out_sequence), 64'(rsp.out_sequence));
        cmp_field("out_payload", 64'(want.out_payload), 64'(rsp.out_payload));
        cmp_field("occupancy", 64'(want.occupancy), 64'(rsp.occupancy));
        cmp_field("drop_total", 64'(want.drop_total), 64'(rsp.drop_total));
        cmp_field("loop_ready", 64'(want.loop_ready), 64'(rsp.loop_ready));
        cmp_field("loop_period", want.loop_period, rsp.loop_period);
      end
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int pick;
    int n;
    frl_pkg::cmd_t c;
    logic [63:0] base;

    // Empty-ring failures, unused codes, extreme fields, then a loop taken through
    // stale, shift-overflow and partial deadline-overflow replays.
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PEEK, '0, '0, '0, '0, '0), 1'b1,
                        mk_rsp(frl_pkg::ST_FAIL, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_POP, '0, '0, '0, '0, '0), 1'b1,
                        mk_rsp(frl_pkg::ST_FAIL, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_SNAPSHOT, '0, '0, '0, DL_MAX, '0), 1'b1,
                        mk_rsp(frl_pkg::ST_FAIL, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, '1), 1'b1,
                        mk_rsp(frl_pkg::ST_FAIL, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(OP_UNUSED_LO, '0, '0, '0, '0, '0), 1'b1,
                        mk_rsp(frl_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(OP_UNUSED_HI, '1, '1, '1, '1, '1), 1'b1,
                        mk_rsp(frl_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PUSH, '0, '0, '0, '0, '0), 1'b1,
                        mk_rsp(frl_pkg::ST_OK, '0, '0, '0, 5'd1, '0, 1'b0, '0)});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PUSH, 64'd10, '1, '1, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PEEK, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_SNAPSHOT, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, 32'd3), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_POP, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_SNAPSHOT, '0, '0, '0, DL_MAX, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, 32'd2), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_SNAPSHOT, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PUSH, DL_MAX, 32'h8000_0000, 32'h5A5A_A5A5,
                               '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_SNAPSHOT, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, 32'd1), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_PEEK, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_RESTORE, '0, '0, '0, '0, 32'd1), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_POP, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_POP, '0, '0, '0, '0, '0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(frl_pkg::OP_POP, '0, '0, '0, '0, '0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) issue(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);

    // Random scenarios: loop replays, fill bursts, drains and noise.
    while (sent < N_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 3) begin
        // Build a short run of frames, freeze it and replay it a few times.
        n = $urandom_range(1, 6);
        base = rand_deadline();
        repeat (n) begin
          c = rand_cmd(frl_pkg::OP_PUSH);
          c.in_deadline = base;
          issue(c);
          base = base + 64'($urandom_range(1, 500));
        end
        c = rand_cmd(frl_pkg::OP_SNAPSHOT);
        case ($urandom_range(3))
          0, 1: c.loop_length = '0;
          2: c.loop_length = 64'($urandom_range(1, 1000));
          default: begin
          end
        endcase
        issue(c);
        repeat ($urandom_range(2, 6)) begin
          case ($urandom_range(5))
            0, 1, 2: begin
              c = rand_cmd(frl_pkg::OP_RESTORE);
              c.iteration = last_iter + 32'($urandom_range(1, 4));
            end
            3: begin
              c = rand_cmd(frl_pkg::OP_RESTORE);
              if ($urandom_range(3) != 0) c.iteration = last_iter - 32'($urandom_range(0, 2));
            end
            4: c = rand_cmd(frl_pkg::OP_POP);
            default: begin
              c = rand_cmd($urandom_range(1) ? frl_pkg::OP_PUSH : frl_pkg::OP_PEEK);
              c.in_deadline = rand_deadline();
            end
          endcase
          issue(c);
        end
      end else if (pick < 5) begin
        // Up to 20 pushes, often enough to reach a full ring and count drops.
        repeat ($urandom_range(15, 20)) begin
          c = rand_cmd(frl_pkg::OP_PUSH);
          c.in_deadline = rand_deadline();
          issue(c);
        end
      end else if (pick < 7) begin
        // Drain, often past empty.
        repeat ($urandom_range(1, 18)) begin
          issue(rand_cmd(($urandom_range(9) < 7) ? frl_pkg::OP_POP : frl_pkg::OP_PEEK));
        end
      end else begin
        repeat ($urandom_range(1, 8)) issue(rand_cmd(3'($urandom_range(7))));
      end
    end

    // Stop sending, wait out the last responses, then allow for any stray beat.
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
